// ===== hw/rtl/wdsm_pkg.sv =====
`timescale 1ns / 1ps

package wdsm_pkg;

	localparam int unsigned WHEEL_COUNT = 2;
	localparam int unsigned WIDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIRECTION_TARGET_MIN  = 3'd0,
		REG_OPPOSITE_SPEED_MIN    = 3'd1,
		REG_DIRECTION_DEBOUNCE_MS = 3'd2,
		REG_STALL_ARM_DELAY_MS    = 3'd3,
		REG_STALL_TARGET_MIN      = 3'd4,
		REG_STALL_PWM_MIN         = 3'd5,
		REG_STALL_SPEED_MAX       = 3'd6,
		REG_STALL_DEBOUNCE_MS     = 3'd7
	} cfg_reg_e;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_ENCODER = 2'd1,
		FAULT_STALL   = 2'd2
	} fault_kind_e;

	typedef struct packed {
		logic [15:0] direction_target_min;
		logic [15:0] opposite_speed_min;
		logic [31:0] direction_debounce_ms;
		logic [31:0] stall_arm_delay_ms;
		logic [15:0] stall_target_min;
		logic [15:0] stall_pwm_min;
		logic [15:0] stall_speed_max;
		logic [31:0] stall_debounce_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         wheel_number;
		logic signed [15:0] target_speed;
		logic signed [15:0] measured_speed;
		logic signed [15:0] drive_pwm;
		logic [31:0]        time_ms;
	} obs_t;

	typedef struct packed {
		logic [1:0] fault_kind;
		logic       fault_wheel;
	} fault_t;

	function automatic logic [16:0] abs16(input logic signed [15:0] v);
		logic signed [16:0] e;
		e = {v[15], v};
		return v[15] ? 17'(-e) : 17'(e);
	endfunction

	function automatic logic waited(input logic [31:0] now, input logic [31:0] then_ms,
			input logic [31:0] span);
		logic [31:0] d;
		d = now - then_ms;
		return d >= span;
	endfunction

endpackage

// ===== hw/rtl/wdsm_cfg.sv =====
`timescale 1ns / 1ps

module wdsm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wdsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data,
	output wdsm_pkg::cfg_t                     cfg
);

	wdsm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction_target_min  <= 16'd50;
			cfg_q.opposite_speed_min    <= 16'd50;
			cfg_q.direction_debounce_ms <= 32'd200;
			cfg_q.stall_arm_delay_ms    <= 32'd500;
			cfg_q.stall_target_min      <= 16'd100;
			cfg_q.stall_pwm_min         <= 16'd300;
			cfg_q.stall_speed_max       <= 16'd20;
			cfg_q.stall_debounce_ms     <= 32'd500;
		end else if (cfg_valid && cfg_ready) begin
			case (wdsm_pkg::cfg_reg_e'(cfg_index))
				wdsm_pkg::REG_DIRECTION_TARGET_MIN: begin
					cfg_q.direction_target_min <= cfg_data[15:0];
				end
				wdsm_pkg::REG_OPPOSITE_SPEED_MIN: begin
					cfg_q.opposite_speed_min <= cfg_data[15:0];
				end
				wdsm_pkg::REG_DIRECTION_DEBOUNCE_MS: begin
					cfg_q.direction_debounce_ms <= cfg_data;
				end
				wdsm_pkg::REG_STALL_ARM_DELAY_MS: begin
					cfg_q.stall_arm_delay_ms <= cfg_data;
				end
				wdsm_pkg::REG_STALL_TARGET_MIN: begin
					cfg_q.stall_target_min <= cfg_data[15:0];
				end
				wdsm_pkg::REG_STALL_PWM_MIN: begin
					cfg_q.stall_pwm_min <= cfg_data[15:0];
				end
				wdsm_pkg::REG_STALL_SPEED_MAX: begin
					cfg_q.stall_speed_max <= cfg_data[15:0];
				end
				wdsm_pkg::REG_STALL_DEBOUNCE_MS: begin
					cfg_q.stall_debounce_ms <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/wheel_direction_stall_monitor.sv =====
`timescale 1ns / 1ps
// channel   signals                           payload
// obs       obs_valid / obs_stall / obs       wheel, target, measured, pwm, time
// fault     fault_valid / fault_stall / fault fault_kind, fault_wheel
// cfg       cfg_valid / cfg_ready             cfg_index, cfg_data
//
// One observation per cycle while obs_stall is low; a result passes through the input
// register, then the per-wheel state update and result register.
// Reset restores register defaults and clears all per-wheel tracking flags.
// A stalled result holds the input register; obs_stall rises only when both are full.

module wheel_direction_stall_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           obs_valid,
	output logic                           obs_stall,
	input  wdsm_pkg::obs_t                 obs,
	output logic                           fault_valid,
	input  logic                           fault_stall,
	output wdsm_pkg::fault_t               fault,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wdsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int unsigned WN = wdsm_pkg::WHEEL_COUNT;
	localparam int unsigned WW = wdsm_pkg::WIDX_W;

	wdsm_pkg::cfg_t   cfg;
	wdsm_pkg::obs_t   obs_s1;
	logic             obs_valid_s1;
	wdsm_pkg::fault_t fault_q;
	logic             fault_valid_q;
	logic             advance;

	logic        observing_q         [WN];
	logic        target_negative_q   [WN];
	logic        reversal_tracking_q [WN];
	logic        stall_tracking_q    [WN];
	logic [31:0] drive_start_q       [WN];
	logic [31:0] reversal_start_q    [WN];
	logic [31:0] stall_start_q       [WN];

	logic              wheel_ok;
	logic [WW-1:0]     widx;
	logic [16:0]       t_abs, m_abs, p_abs;
	logic              idle, neg, restart, rt, st, reversed, enc_fault, stall_cond;
	logic              stall_fault;
	logic [31:0]       ds_eff;
	logic signed [17:0] meas18, opp18;

	wdsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance   = obs_valid_s1 && (!fault_valid_q || !fault_stall);
	assign obs_stall = obs_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obs_valid_s1 <= 1'b0;
		end else if (!obs_stall) begin
			obs_valid_s1 <= obs_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!obs_stall && obs_valid) begin
			obs_s1 <= obs;
		end
	end

	always_comb begin
		wheel_ok = (obs_s1.wheel_number != 2'd0) && (32'(obs_s1.wheel_number) <= WN);
		widx     = WW'(32'(obs_s1.wheel_number) - 32'd1);
		t_abs    = wdsm_pkg::abs16(obs_s1.target_speed);
		m_abs    = wdsm_pkg::abs16(obs_s1.measured_speed);
		p_abs    = wdsm_pkg::abs16(obs_s1.drive_pwm);
		idle     = t_abs < {1'b0, cfg.direction_target_min};
		neg      = obs_s1.target_speed[15] || (obs_s1.target_speed == 16'sd0);
		restart  = !observing_q[widx] || (target_negative_q[widx] != neg);
		rt       = !restart && reversal_tracking_q[widx];
		st       = !restart && stall_tracking_q[widx];
		ds_eff   = restart ? obs_s1.time_ms : drive_start_q[widx];
		meas18   = {{2{obs_s1.measured_speed[15]}}, obs_s1.measured_speed};
		opp18    = {2'b00, cfg.opposite_speed_min};
		reversed = neg ? (meas18 >= opp18) : (meas18 <= -opp18);
		enc_fault = reversed && rt &&
			wdsm_pkg::waited(obs_s1.time_ms, reversal_start_q[widx],
				cfg.direction_debounce_ms);
		stall_cond = wdsm_pkg::waited(obs_s1.time_ms, ds_eff, cfg.stall_arm_delay_ms) &&
			(t_abs >= {1'b0, cfg.stall_target_min}) &&
			(p_abs >= {1'b0, cfg.stall_pwm_min}) &&
			(m_abs <= {1'b0, cfg.stall_speed_max});
		stall_fault = !enc_fault && stall_cond && st &&
			wdsm_pkg::waited(obs_s1.time_ms, stall_start_q[widx], cfg.stall_debounce_ms);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WN; i++) begin
				observing_q[i]         <= 1'b0;
				target_negative_q[i]   <= 1'b0;
				reversal_tracking_q[i] <= 1'b0;
				stall_tracking_q[i]    <= 1'b0;
			end
		end else if (advance && wheel_ok) begin
			if (idle) begin
				observing_q[widx]         <= 1'b0;
				reversal_tracking_q[widx] <= 1'b0;
				stall_tracking_q[widx]    <= 1'b0;
			end else begin
				observing_q[widx]         <= 1'b1;
				target_negative_q[widx]   <= neg;
				reversal_tracking_q[widx] <= reversed;
				stall_tracking_q[widx]    <= enc_fault ? st : stall_cond;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wheel_ok && !idle) begin
			if (restart) begin
				drive_start_q[widx] <= obs_s1.time_ms;
			end
			if (reversed && !rt) begin
				reversal_start_q[widx] <= obs_s1.time_ms;
			end
			if (!enc_fault && stall_cond && !st) begin
				stall_start_q[widx] <= obs_s1.time_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_valid_q <= 1'b0;
		end else if (advance) begin
			fault_valid_q <= 1'b1;
		end else if (!fault_stall) begin
			fault_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (wheel_ok && !idle && enc_fault) begin
				fault_q.fault_kind  <= wdsm_pkg::FAULT_ENCODER;
				fault_q.fault_wheel <= widx[0];
			end else if (wheel_ok && !idle && stall_fault) begin
				fault_q.fault_kind  <= wdsm_pkg::FAULT_STALL;
				fault_q.fault_wheel <= widx[0];
			end else begin
				fault_q.fault_kind  <= wdsm_pkg::FAULT_NONE;
				fault_q.fault_wheel <= 1'b0;
			end
		end
	end

	assign fault_valid = fault_valid_q;
	assign fault       = fault_q;

`ifndef NO_ASSERTIONS
	a_none_wheel0: assert property (@(posedge clk) disable iff (!arst_n)
		(fault_valid && fault.fault_kind == wdsm_pkg::FAULT_NONE) |-> !fault.fault_wheel)
		else $error("fault_wheel set with no fault");

	a_ignored_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !wheel_ok) |=> fault.fault_kind == wdsm_pkg::FAULT_NONE)
		else $error("fault raised for ignored wheel");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		obs_stall |-> (fault_valid_q && fault_stall && obs_valid_s1))
		else $error("input stalled with room downstream");

	a_enc_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && wheel_ok && !idle && enc_fault) |=> reversal_tracking_q[$past(widx)])
		else $error("encoder fault without reversal tracking");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

import wdsm_pkg::*;

class fault_scoreboard;
	cfg_t       cfg;
	bit         monitoring[WHEEL_COUNT];
	bit         heading_back[WHEEL_COUNT];
	bit         rev_seen[WHEEL_COUNT];
	bit         stall_seen[WHEEL_COUNT];
	logic [31:0] run_start_ms[WHEEL_COUNT];
	logic [31:0] rev_since_ms[WHEEL_COUNT];
	logic [31:0] stall_since_ms[WHEEL_COUNT];
	fault_t     expected_faults[$];
	int         mismatches;

	function new();
		cfg.direction_target_min  = 16'd50;
		cfg.opposite_speed_min    = 16'd50;
		cfg.direction_debounce_ms = 32'd200;
		cfg.stall_arm_delay_ms    = 32'd500;
		cfg.stall_target_min      = 16'd100;
		cfg.stall_pwm_min         = 16'd300;
		cfg.stall_speed_max       = 16'd20;
		cfg.stall_debounce_ms     = 32'd500;
		foreach (monitoring[i]) begin
			monitoring[i]     = 1'b0;
			heading_back[i]   = 1'b0;
			rev_seen[i]       = 1'b0;
			stall_seen[i]     = 1'b0;
			run_start_ms[i]   = '0;
			rev_since_ms[i]   = '0;
			stall_since_ms[i] = '0;
		end
		mismatches = 0;
	endfunction

	function bit has_lasted(logic [31:0] now_ms, logic [31:0] since_ms, logic [31:0] span);
		logic [31:0] d;
		d = now_ms - since_ms;
		return d >= span;
	endfunction

	function void write_reg(cfg_reg_e idx, logic [31:0] v);
		case (idx)
			REG_DIRECTION_TARGET_MIN:  cfg.direction_target_min  = v[15:0];
			REG_OPPOSITE_SPEED_MIN:    cfg.opposite_speed_min    = v[15:0];
			REG_DIRECTION_DEBOUNCE_MS: cfg.direction_debounce_ms = v;
			REG_STALL_ARM_DELAY_MS:    cfg.stall_arm_delay_ms    = v;
			REG_STALL_TARGET_MIN:      cfg.stall_target_min      = v[15:0];
			REG_STALL_PWM_MIN:         cfg.stall_pwm_min         = v[15:0];
			REG_STALL_SPEED_MAX:       cfg.stall_speed_max       = v[15:0];
			REG_STALL_DEBOUNCE_MS:     cfg.stall_debounce_ms     = v;
			default: ;
		endcase
	endfunction

	function void note_observation(obs_t o);
		fault_t      res;
		int          w, tgt, meas, pwm, t_abs, m_abs, p_abs, opp;
		bit          neg, reversed, encoder;
		logic [31:0] now_ms;
		res = '0;
		tgt = o.target_speed;
		meas = o.measured_speed;
		pwm = o.drive_pwm;
		now_ms = o.time_ms;
		if (o.wheel_number >= 1 && o.wheel_number <= WHEEL_COUNT) begin
			w = o.wheel_number - 1;
			t_abs = tgt < 0 ? -tgt : tgt;
			m_abs = meas < 0 ? -meas : meas;
			p_abs = pwm < 0 ? -pwm : pwm;
			if (t_abs < int'(cfg.direction_target_min)) begin
				monitoring[w] = 1'b0;
				rev_seen[w] = 1'b0;
				stall_seen[w] = 1'b0;
			end else begin
				// zero target counts as reverse heading
				neg = !(tgt > 0);
				if (!monitoring[w] || heading_back[w] != neg) begin
					monitoring[w] = 1'b1;
					run_start_ms[w] = now_ms;
					heading_back[w] = neg;
					rev_seen[w] = 1'b0;
					stall_seen[w] = 1'b0;
				end
				opp = int'(cfg.opposite_speed_min);
				reversed = neg ? (meas >= opp) : (meas <= -opp);
				encoder = 1'b0;
				if (reversed) begin
					if (!rev_seen[w]) begin
						rev_seen[w] = 1'b1;
						rev_since_ms[w] = now_ms;
					end else if (has_lasted(now_ms, rev_since_ms[w],
							cfg.direction_debounce_ms)) begin
						res.fault_kind = FAULT_ENCODER;
						res.fault_wheel = w[0];
						encoder = 1'b1;
					end
				end else begin
					rev_seen[w] = 1'b0;
				end
				// stall tracking untouched on an encoder fault
				if (!encoder) begin
					if (has_lasted(now_ms, run_start_ms[w], cfg.stall_arm_delay_ms) &&
							t_abs >= int'(cfg.stall_target_min) &&
							p_abs >= int'(cfg.stall_pwm_min) &&
							m_abs <= int'(cfg.stall_speed_max)) begin
						if (!stall_seen[w]) begin
							stall_seen[w] = 1'b1;
							stall_since_ms[w] = now_ms;
						end else if (has_lasted(now_ms, stall_since_ms[w],
								cfg.stall_debounce_ms)) begin
							res.fault_kind = FAULT_STALL;
							res.fault_wheel = w[0];
						end
					end else begin
						stall_seen[w] = 1'b0;
					end
				end
			end
		end
		expected_faults.push_back(res);
	endfunction

	function void check_fault(fault_t got);
		fault_t want;
		if (expected_faults.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("fault transfer with nothing pending: kind %0d wheel %0d",
					got.fault_kind, got.fault_wheel);
			return;
		end
		want = expected_faults.pop_front();
		if (got.fault_kind !== want.fault_kind || got.fault_wheel !== want.fault_wheel) begin
			mismatches++;
			if (mismatches <= 10)
				$display("fault mismatch: expected kind %0d wheel %0d, got kind %0d wheel %0d",
					want.fault_kind, want.fault_wheel, got.fault_kind, got.fault_wheel);
		end
	endfunction
endclass

module tb_top;

	typedef enum {DRIVE_NORMAL, DRIVE_STALLED, DRIVE_REVERSED, DRIVE_IDLE} drive_mode_e;

	localparam int QUIET_LIMIT = 1000;
	localparam int LONG_HOLD = 120;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 obs_valid = 1'b0;
	logic                 obs_stall;
	obs_t                 obs = '0;
	logic                 fault_valid;
	logic                 fault_stall = 1'b0;
	fault_t               fault;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	fault_scoreboard sb = new();
	int              quiet_cycles = 0;
	bit              idling_on = 1'b1;
	bit              long_hold_req = 1'b0;
	logic [31:0]     clock_ms = '0;
	drive_mode_e     drive_mode[WHEEL_COUNT];
	bit              drive_back[WHEEL_COUNT];

	wheel_direction_stall_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.obs_valid(obs_valid),
		.obs_stall(obs_stall),
		.obs(obs),
		.fault_valid(fault_valid),
		.fault_stall(fault_stall),
		.fault(fault),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin : transfer_monitor
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (obs_valid && !obs_stall) begin
				sb.note_observation(obs);
				moved = 1'b1;
			end
			if (fault_valid && !fault_stall) begin
				sb.check_fault(fault);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_reg_e'(cfg_index), cfg_data);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : fault_sink
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				fault_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				fault_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				fault_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				fault_stall <= 1'b0;
			end
		end
	end

	task automatic send_obs(input obs_t o);
		obs <= o;
		obs_valid <= 1'b1;
		@(posedge clk);
		while (obs_stall) @(posedge clk);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			obs_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic offer_obs(input logic [1:0] wheel, input int tgt, input int meas,
			input int pwm, input logic [31:0] at_ms);
		obs_t o;
		o.wheel_number = wheel;
		o.target_speed = 16'(tgt);
		o.measured_speed = 16'(meas);
		o.drive_pwm = 16'(pwm);
		o.time_ms = at_ms;
		send_obs(o);
	endtask

	task automatic drain_results();
		obs_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_faults.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_settings(input logic [31:0] dir_min, input logic [31:0] opp_min,
			input logic [31:0] dir_deb, input logic [31:0] arm, input logic [31:0] st_min,
			input logic [31:0] pwm_min, input logic [31:0] spd_max, input logic [31:0] st_deb);
		write_reg(REG_DIRECTION_TARGET_MIN, dir_min);
		write_reg(REG_OPPOSITE_SPEED_MIN, opp_min);
		write_reg(REG_DIRECTION_DEBOUNCE_MS, dir_deb);
		write_reg(REG_STALL_ARM_DELAY_MS, arm);
		write_reg(REG_STALL_TARGET_MIN, st_min);
		write_reg(REG_STALL_PWM_MIN, pwm_min);
		write_reg(REG_STALL_SPEED_MAX, spd_max);
		write_reg(REG_STALL_DEBOUNCE_MS, st_deb);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_random_settings();
		write_settings($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 400),
			$urandom_range(0, 800), $urandom_range(0, 300), $urandom_range(0, 600),
			$urandom_range(0, 80), $urandom_range(0, 400));
	endtask

	// mostly coherent drive sequences per wheel, with some raw noise
	function automatic obs_t random_obs();
		obs_t o;
		int   w, mag, pmag;
		clock_ms += $urandom_range(0, 120);
		if ($urandom_range(0, 39) == 0)
			clock_ms += $urandom;
		if ($urandom_range(0, 9) == 0) begin
			o.wheel_number = 2'($urandom);
			o.target_speed = 16'($urandom);
			o.measured_speed = 16'($urandom);
			o.drive_pwm = 16'($urandom);
			o.time_ms = $urandom_range(0, 1) ? $urandom : clock_ms;
			return o;
		end
		w = $urandom_range(0, WHEEL_COUNT - 1);
		if ($urandom_range(0, 11) == 0)
			drive_mode[w] = drive_mode_e'($urandom_range(0, 3));
		if ($urandom_range(0, 15) == 0)
			drive_back[w] = ~drive_back[w];
		o.wheel_number = 2'(w + 1);
		o.time_ms = clock_ms;
		mag = (drive_mode[w] == DRIVE_IDLE) ? $urandom_range(0, 60) : $urandom_range(0, 1500);
		o.target_speed = 16'(drive_back[w] ? -mag : mag);
		if ($urandom_range(0, 19) == 0)
			o.target_speed = 16'sh8000;
		case (drive_mode[w])
			DRIVE_STALLED:  o.measured_speed = 16'($urandom_range(0, 80) - 40);
			DRIVE_REVERSED: begin
				mag = $urandom_range(0, 400);
				o.measured_speed = 16'(drive_back[w] ? mag : -mag);
			end
			default: begin
				mag = $urandom_range(0, 1500);
				o.measured_speed = 16'(drive_back[w] ? -mag : mag);
			end
		endcase
		pmag = $urandom_range(0, 2000);
		if ($urandom_range(0, 7) == 0)
			o.drive_pwm = 16'(drive_back[w] ? pmag : -pmag);
		else
			o.drive_pwm = 16'(drive_back[w] ? -pmag : pmag);
		return o;
	endfunction

	task automatic run_random(input int count);
		repeat (count) send_obs(random_obs());
	endtask

	initial begin : stimulus
		foreach (drive_mode[i]) begin
			drive_mode[i] = DRIVE_NORMAL;
			drive_back[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: ignored wheels, stall and encoder faults, wrap
		offer_obs(2'd0, -32768, -32768, -32768, 32'hFFFF_FFFF);
		offer_obs(2'd3, 32767, 32767, 32767, 32'h0);
		offer_obs(2'd1, 1000, 0, 1000, 32'd0);
		offer_obs(2'd1, 1000, 0, 1000, 32'd600);
		offer_obs(2'd1, 1000, 10, -1000, 32'd1100);
		offer_obs(2'd1, 1000, 5, 1000, 32'd1150);
		offer_obs(2'd1, 1000, -100, 1000, 32'd1200);
		offer_obs(2'd1, 1000, -100, 1000, 32'd1400);
		offer_obs(2'd1, 1000, -100, 1000, 32'd1450);
		offer_obs(2'd1, -1000, -100, 1000, 32'd1500);
		offer_obs(2'd1, 49, 0, 1000, 32'd1600);
		offer_obs(2'd2, -32768, 32767, -32768, 32'hFFFF_FF00);
		offer_obs(2'd2, -32768, 32767, -32768, 32'h0000_0010);
		offer_obs(2'd2, 0, 0, 0, 32'h20);
		offer_obs(2'd2, 32767, 32767, 32767, 32'h30);
		drain_results();

		// all thresholds zero: zero target heads back, zero debounce
		write_settings(0, 0, 0, 0, 0, 0, 0, 0);
		offer_obs(2'd1, 0, 0, 0, 32'd5);
		offer_obs(2'd1, 0, 0, 0, 32'd5);
		offer_obs(2'd2, 0, -5, 0, 32'd7);
		run_random(120);
		drain_results();

		write_settings(32768, 32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32768, 32768, 32768,
			32'hFFFF_FFFF);
		offer_obs(2'd1, -32768, 0, -32768, 32'd9);
		offer_obs(2'd2, 32767, -32768, 32767, 32'd10);
		run_random(60);
		drain_results();

		write_settings(50, 50, 200, 500, 100, 300, 20, 500);
		long_hold_req = 1'b1;
		run_random(160);
		drain_results();

		write_random_settings();
		clock_ms = 32'hFFFF_F000;
		run_random(150);
		drain_results();

		write_random_settings();
		run_random(100);
		drain_results();

		idling_on = 1'b0;
		write_random_settings();
		run_random(100);
		drain_results();

		if (sb.expected_faults.size() != 0)
			$display("%0d expected fault results never arrived", sb.expected_faults.size());
		if (sb.mismatches == 0 && sb.expected_faults.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
